// ===== sv/lwsam_pkg.sv =====
// Shared types and constants for the longest window sum search block.
package lwsam_pkg;

  localparam int WINDOW_DEPTH_DEF = 1024;
  localparam int VALUE_W          = 16;
  localparam int LEN_W            = 11;
  localparam int LIMIT_W          = 26;
  localparam int SUM_W            = 27;
  localparam int QUEUE_DEPTH      = 2;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] best_length;
    logic [LEN_W-1:0] window_length;
    logic             overflow;
  } out_t;

endpackage

// ===== sv/lwsam_queue.sv =====
// Front end: accepts input items into a short register queue.
module lwsam_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lwsam_pkg::in_t  in_data_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output lwsam_pkg::in_t  q_data_o
);
  import lwsam_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  in_t            entry_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic           push, pop;

  assign in_ready_o = (fill_q != CW'(QUEUE_DEPTH));
  assign q_valid_o  = (fill_q != '0);
  assign q_data_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// ===== sv/lwsam_engine.sv =====
// Back end: window store, running sum, pop loop and the output register.
module lwsam_engine #(
  parameter int WINDOW_DEPTH = lwsam_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lwsam_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  lwsam_pkg::in_t                q_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lwsam_pkg::out_t               out_data_o
);
  import lwsam_pkg::*;

  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_CHECK,
    S_POP,
    S_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [IW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CW-1:0]      best_q, best_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_data_q, out_data_d;

  logic [VALUE_W-1:0] window_mem_q [WINDOW_DEPTH];
  logic [VALUE_W-1:0] rd_data_q;
  logic               mem_we;
  logic [IW-1:0]      mem_wa, mem_ra;
  logic [VALUE_W-1:0] mem_wd;

  logic [IW-1:0]      head_eff, head_inc, tail;
  logic [CW-1:0]      count_eff;
  logic [SUM_W-1:0]   sum_eff;
  logic [IW:0]        tail_sum;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A first item starts a new array, so the window is seen as empty.
  assign head_eff  = q_data_i.first ? '0 : head_q;
  assign count_eff = q_data_i.first ? '0 : count_q;
  assign sum_eff   = q_data_i.first ? '0 : sum_q;
  assign head_inc  = (head_q == IW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // The tail is only needed when the window is not full, so the count fits IW bits.
  assign tail_sum = {1'b0, head_eff} + {1'b0, count_eff[IW-1:0]};
  assign tail     = (tail_sum >= (IW+1)'(WINDOW_DEPTH))
                  ? IW'(tail_sum - (IW+1)'(WINDOW_DEPTH)) : tail_sum[IW-1:0];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    sum_d       = sum_q;
    best_d      = best_q;
    val_d       = val_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = tail;
    mem_wd      = q_data_i.value;
    mem_ra      = head_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          head_d  = head_eff;
          val_d   = q_data_i.value;
          if (q_data_i.first) begin
            best_d = '0;
          end
          if (count_eff == CW'(WINDOW_DEPTH)) begin
            // Full window: fetch the oldest entry so it can be dropped.
            mem_ra  = head_eff;
            ovf_d   = 1'b1;
            count_d = count_eff;
            sum_d   = sum_eff;
            state_d = S_DROP;
          end else begin
            mem_we  = 1'b1;
            ovf_d   = 1'b0;
            count_d = count_eff + 1'b1;
            sum_d   = sum_eff + SUM_W'(q_data_i.value);
            state_d = S_CHECK;
          end
        end
      end
      S_DROP: begin
        // The new value takes the slot of the dropped one; the count stays full.
        mem_we  = 1'b1;
        mem_wa  = head_q;
        mem_wd  = val_q;
        sum_d   = sum_q - SUM_W'(rd_data_q) + SUM_W'(val_q);
        head_d  = head_inc;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if ((sum_q > SUM_W'(limit_q)) && (count_q != '0)) begin
          state_d = S_POP;
        end else begin
          if (count_q > best_q) begin
            best_d = count_q;
          end
          state_d = S_OUT;
        end
      end
      S_POP: begin
        sum_d   = sum_q - SUM_W'(rd_data_q);
        head_d  = head_inc;
        count_d = count_q - 1'b1;
        state_d = S_CHECK;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d              = 1'b1;
          out_data_d.best_length   = LEN_W'(best_q);
          out_data_d.window_length = LEN_W'(count_q);
          out_data_d.overflow      = ovf_q;
          state_d                  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= '0;
      head_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      best_q      <= '0;
      val_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      best_q      <= best_d;
      val_q       <= val_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      window_mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= window_mem_q[mem_ra];
  end

endmodule

// ===== sv/longest_window_sum_at_most.sv =====
// Streaming search for the longest run of values whose sum stays at or below a limit.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one item per element:
// the value and a first flag that starts a new array. Output channel
// (out_valid_o / out_ready_i / out_data_o) returns one item per input item, in
// order: best length so far, current window length and the overflow flag.
// The limit is written through cfg_we_i / cfg_wdata_i; the user must do this only
// while the block is idle, as the block itself does not enforce it. A two-entry
// queue sits in front of the engine, so items are taken while the engine works and
// while a result waits in the output register. In the engine each item passes
// S_IDLE, S_CHECK and S_OUT, with S_DROP after S_IDLE when the window was full and
// a pass through S_POP and S_CHECK for each entry popped from the window. Every
// pop reads the oldest entry from the single-port read of the window memory, whose
// read data is registered; each entry is popped at most once. The engine takes the
// next item from the queue only after the last one has left S_OUT. When the
// receiver stalls, the result holds in the output register, the engine waits with
// the next result, and the queue fills and drops ready.
// Reset clears the queue, the window, the sum, the best length and the limit;
// the window memory itself is not cleared and needs no clearing pass.
module longest_window_sum_at_most #(
  parameter int WINDOW_DEPTH = lwsam_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lwsam_pkg::in_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lwsam_pkg::out_t               out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lwsam_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import lwsam_pkg::*;

  logic q_valid;
  logic q_pop;
  in_t  q_data;

  lwsam_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_data_o   (q_data)
  );

  lwsam_engine #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the longest window sum search block.
`timescale 1ns / 100ps

module tb_top;
  import lwsam_pkg::*;

  localparam int WIN_DEPTH = WINDOW_DEPTH_DEF;
  localparam int CYCLE_CAP = 500000;
  localparam int RANDOM_ITEMS = 750;
  localparam int LONG_ARRAY = 1100;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef struct {
    bit                 load;
    logic [LIMIT_W-1:0] limit;
    in_t                item;
    bit                 typed;
    out_t               exp;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wdata_i = '0;

  // Predictor state: a shadow of the window, its sum and the best length.
  logic [VALUE_W-1:0]   win_mem [WIN_DEPTH];
  int unsigned          head;
  int unsigned          fill;
  longint unsigned      acc;
  int unsigned          best;
  logic [LIMIT_W-1:0]   sum_cap;

  out_t                 lengths_due [$];
  int                   mismatches = 0;
  int                   cycle_count = 0;
  bit                   steady;

  longest_window_sum_at_most #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void drop_oldest();
    acc  -= win_mem[head];
    head  = (head + 1) % WIN_DEPTH;
    fill -= 1;
  endfunction

  function automatic out_t advance_window(in_t it);
    out_t        r;
    int unsigned tail;
    r = '0;
    if (it.first) begin
      head = 0;
      fill = 0;
      acc  = 0;
      best = 0;
    end
    if (fill >= WIN_DEPTH) begin
      drop_oldest();
      r.overflow = 1'b1;
    end
    tail          = (head + fill) % WIN_DEPTH;
    win_mem[tail] = it.value;
    fill         += 1;
    acc          += it.value;
    while (acc > sum_cap && fill > 0) drop_oldest();
    if (fill > best) best = fill;
    r.best_length   = LEN_W'(best);
    r.window_length = LEN_W'(fill);
    return r;
  endfunction

  always @(negedge clk_i) out_ready_i <= steady || ($urandom_range(0, 99) >= 11);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** longest_window_sum_at_most: FAILED **");
      $finish;
    end
  end

  // Each result is checked against the oldest expectation still waiting.
  always @(posedge clk_i) begin
    out_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lengths_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result best %0d win %0d ovf %0d", $realtime,
                   out_data_o.best_length, out_data_o.window_length, out_data_o.overflow);
        end
      end else begin
        exp = lengths_due.pop_front();
        if (out_data_o.best_length !== exp.best_length ||
            out_data_o.window_length !== exp.window_length ||
            out_data_o.overflow !== exp.overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch best %0d/%0d win %0d/%0d ovf %0d/%0d (exp/got)",
                     $realtime, exp.best_length, out_data_o.best_length,
                     exp.window_length, out_data_o.window_length,
                     exp.overflow, out_data_o.overflow);
          end
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_item(input in_t it, input bit typed, input out_t typed_exp);
    out_t predicted;
    while (!steady && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = advance_window(it);
    lengths_due.push_back(typed ? typed_exp : predicted);
    @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] limit);
    in_valid_i <= 1'b0;
    while (lengths_due.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    sum_cap      = limit;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(logic [LIMIT_W-1:0] limit);
    longint unsigned cap;
    int unsigned     k;
    cap = limit / 4;
    if (cap < 1) cap = 1;
    if (cap > 16'hFFFF) cap = 16'hFFFF;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k == 2) return VALUE_W'($urandom);
    return VALUE_W'($urandom_range(0, int'(cap)));
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LIMIT_MAX;
      2: return LIMIT_W'($urandom_range(0, 2000));
      3: return LIMIT_W'($urandom_range(0, 524288));
      4: return LIMIT_W'($urandom);
      default: return LIMIT_W'($urandom_range(65536, 1 << 20));
    endcase
  endfunction

  // Directed rows. The first block runs on the limit left by reset.
  plan_row_t plan [] = '{
    '{0, '0,          '{16'h0000, 1'b1}, 1, '{11'd1, 11'd1, 1'b0}},
    '{0, '0,          '{16'h0000, 1'b0}, 1, '{11'd2, 11'd2, 1'b0}},
    '{0, '0,          '{16'h0001, 1'b0}, 1, '{11'd2, 11'd0, 1'b0}},
    '{0, '0,          '{16'hFFFF, 1'b1}, 1, '{11'd0, 11'd0, 1'b0}},
    '{1, LIMIT_MAX,   '{16'hFFFF, 1'b1}, 1, '{11'd1, 11'd1, 1'b0}},
    '{0, '0,          '{16'hFFFF, 1'b0}, 1, '{11'd2, 11'd2, 1'b0}},
    '{0, '0,          '{16'h0000, 1'b0}, 1, '{11'd3, 11'd3, 1'b0}},
    '{1, 26'd100,     '{16'd60,   1'b1}, 1, '{11'd1, 11'd1, 1'b0}},
    '{0, '0,          '{16'd40,   1'b0}, 1, '{11'd2, 11'd2, 1'b0}},
    '{0, '0,          '{16'd1,    1'b0}, 1, '{11'd2, 11'd2, 1'b0}},
    '{0, '0,          '{16'd100,  1'b0}, 1, '{11'd2, 11'd1, 1'b0}},
    '{0, '0,          '{16'd101,  1'b0}, 1, '{11'd2, 11'd0, 1'b0}},
    '{0, '0,          '{16'd5,    1'b1}, 1, '{11'd1, 11'd1, 1'b0}},
    '{1, 26'h2AAAAAA, '{16'hAAAA, 1'b1}, 0, '0},
    '{0, '0,          '{16'h5555, 1'b0}, 0, '0},
    '{0, '0,          '{16'hFFFF, 1'b0}, 0, '0},
    '{1, 26'h1555555, '{16'h5555, 1'b0}, 0, '0},
    '{0, '0,          '{16'hAAAA, 1'b0}, 0, '0}
  };

  initial begin
    int             sent;
    int             arrays;
    int             span;
    logic [LIMIT_W-1:0] limit;
    in_t            it;
    head        = 0;
    fill        = 0;
    acc         = 0;
    best        = 0;
    sum_cap     = '0;
    steady      = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].load) write_limit(plan[i].limit);
      push_item(plan[i].item, plan[i].typed, plan[i].exp);
    end

    // Random arrays under a random limit per phase; some arrays continue the
    // previous one and some restart in the middle.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      limit = pick_limit();
      write_limit(limit);
      arrays = $urandom_range(1, 4);
      repeat (arrays) begin
        span = $urandom_range(1, 48);
        for (int j = 0; j < span; j++) begin
          steady   = (sent >= 300 && sent < 500);
          it.value = pick_value(limit);
          if (j == 0) it.first = ($urandom_range(0, 9) != 0);
          else        it.first = ($urandom_range(0, 19) == 0);
          push_item(it, 1'b0, '0);
          sent++;
        end
      end
    end
    steady = 1'b0;

    // One array longer than the window depth, so the full-window drop and
    // the wrap of the store both happen.
    write_limit(LIMIT_MAX);
    for (int j = 0; j < LONG_ARRAY; j++) begin
      it.value = pick_value(LIMIT_MAX);
      it.first = (j == 0);
      push_item(it, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (lengths_due.size() != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** longest_window_sum_at_most: PASSED **");
    end else begin
      $display("** longest_window_sum_at_most: FAILED **");
    end
    $finish;
  end

endmodule
